// ===== src/tked_pkg.sv =====
// ----------------------------------------------------------------------------
// tked_pkg
// shared types, key codes, byte codes and the escape sequence key table
// ----------------------------------------------------------------------------
package tked_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [4:0] key_code_t;

  // key codes
  localparam key_code_t KEY_CHAR  = 5'd0;
  localparam key_code_t KEY_BREAK = 5'd1;
  localparam key_code_t KEY_BACK  = 5'd2;
  localparam key_code_t KEY_TAB   = 5'd3;
  localparam key_code_t KEY_ENTER = 5'd4;
  localparam key_code_t KEY_ESC   = 5'd5;
  localparam key_code_t KEY_F1    = 5'd6;
  localparam key_code_t KEY_F2    = 5'd7;
  localparam key_code_t KEY_F3    = 5'd8;
  localparam key_code_t KEY_F4    = 5'd9;
  localparam key_code_t KEY_F5    = 5'd10;
  localparam key_code_t KEY_F6    = 5'd11;
  localparam key_code_t KEY_F7    = 5'd12;
  localparam key_code_t KEY_F8    = 5'd13;
  localparam key_code_t KEY_F9    = 5'd14;
  localparam key_code_t KEY_F10   = 5'd15;
  localparam key_code_t KEY_F11   = 5'd16;
  localparam key_code_t KEY_F12   = 5'd17;
  localparam key_code_t KEY_INS   = 5'd18;
  localparam key_code_t KEY_DEL   = 5'd19;
  localparam key_code_t KEY_PGUP  = 5'd20;
  localparam key_code_t KEY_PGDN  = 5'd21;
  localparam key_code_t KEY_UP    = 5'd22;
  localparam key_code_t KEY_DOWN  = 5'd23;
  localparam key_code_t KEY_RIGHT = 5'd24;
  localparam key_code_t KEY_LEFT  = 5'd25;
  localparam key_code_t KEY_END   = 5'd26;
  localparam key_code_t KEY_HOME  = 5'd27;

  // received byte codes
  localparam byte_t BYTE_NONE      = 8'h00;
  localparam byte_t BYTE_BREAK     = 8'h03;
  localparam byte_t BYTE_TAB       = 8'h09;
  localparam byte_t BYTE_CR        = 8'h0D;
  localparam byte_t BYTE_ESC       = 8'h1B;
  localparam byte_t BYTE_SPACE     = 8'h20;
  localparam byte_t BYTE_DEL       = 8'h7F;
  localparam byte_t BYTE_CSI       = 8'h5B; // '['
  localparam byte_t BYTE_SS3       = 8'h4F; // 'O'
  localparam byte_t BYTE_FINAL_MIN = 8'h41; // 'A'

  // sequence length counter, saturating one below the limit
  localparam int SEQ_LIMIT = 14;
  localparam int LEN_MAX   = SEQ_LIMIT - 1;
  localparam int LEN_W     = $clog2(SEQ_LIMIT);
  localparam int SEQ_KEEP  = 4;

  typedef logic [LEN_W-1:0] seq_len_t;
  typedef byte_t seq_bytes_t [SEQ_KEEP];

  // queue between decoder and output side
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    key_code_t code;
    byte_t     chr;
  } result_t;

  // one decoded item: one or two results
  typedef struct packed {
    logic    two;
    result_t r0;
    result_t r1;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } q_head_t;

  typedef struct packed {
    logic      hit;
    key_code_t code;
  } match_t;

  // key table
  localparam int KEY_COUNT = 22;

  localparam logic [2:0] KEY_LEN [KEY_COUNT] = '{
    3'd2, 3'd2, 3'd2, 3'd2,
    3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4,
    3'd3, 3'd3, 3'd3, 3'd3,
    3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2
  };

  localparam seq_bytes_t KEY_SEQ [KEY_COUNT] = '{
    '{BYTE_SS3, 8'h50, 8'h00, 8'h00},   // O P
    '{BYTE_SS3, 8'h51, 8'h00, 8'h00},   // O Q
    '{BYTE_SS3, 8'h52, 8'h00, 8'h00},   // O R
    '{BYTE_SS3, 8'h53, 8'h00, 8'h00},   // O S
    '{BYTE_CSI, 8'h31, 8'h35, 8'h7E},   // [15~
    '{BYTE_CSI, 8'h31, 8'h37, 8'h7E},   // [17~
    '{BYTE_CSI, 8'h31, 8'h38, 8'h7E},   // [18~
    '{BYTE_CSI, 8'h31, 8'h39, 8'h7E},   // [19~
    '{BYTE_CSI, 8'h32, 8'h30, 8'h7E},   // [20~
    '{BYTE_CSI, 8'h32, 8'h31, 8'h7E},   // [21~
    '{BYTE_CSI, 8'h32, 8'h33, 8'h7E},   // [23~
    '{BYTE_CSI, 8'h32, 8'h34, 8'h7E},   // [24~
    '{BYTE_CSI, 8'h32, 8'h7E, 8'h00},   // [2~
    '{BYTE_CSI, 8'h33, 8'h7E, 8'h00},   // [3~
    '{BYTE_CSI, 8'h35, 8'h7E, 8'h00},   // [5~
    '{BYTE_CSI, 8'h36, 8'h7E, 8'h00},   // [6~
    '{BYTE_CSI, 8'h41, 8'h00, 8'h00},   // [A
    '{BYTE_CSI, 8'h42, 8'h00, 8'h00},   // [B
    '{BYTE_CSI, 8'h43, 8'h00, 8'h00},   // [C
    '{BYTE_CSI, 8'h44, 8'h00, 8'h00},   // [D
    '{BYTE_CSI, 8'h46, 8'h00, 8'h00},   // [F
    '{BYTE_CSI, 8'h48, 8'h00, 8'h00}    // [H
  };

  localparam key_code_t KEY_TABLE_CODE [KEY_COUNT] = '{
    KEY_F1, KEY_F2, KEY_F3, KEY_F4,
    KEY_F5, KEY_F6, KEY_F7, KEY_F8, KEY_F9, KEY_F10, KEY_F11, KEY_F12,
    KEY_INS, KEY_DEL, KEY_PGUP, KEY_PGDN,
    KEY_UP, KEY_DOWN, KEY_RIGHT, KEY_LEFT, KEY_END, KEY_HOME
  };

  // exact match of a collected sequence; entries are distinct so at most one hits
  function automatic match_t key_lookup(input seq_len_t len, input seq_bytes_t seq);
    match_t m;
    logic   same;
    m.hit  = 1'b0;
    m.code = KEY_CHAR;
    for (int i = 0; i < KEY_COUNT; i++) begin
      same = ({{(LEN_W){1'b0}}, KEY_LEN[i]} == {3'd0, len});
      for (int j = 0; j < SEQ_KEEP; j++) begin
        if ((j < KEY_LEN[i]) && (KEY_SEQ[i][j] != seq[j])) begin
          same = 1'b0;
        end
      end
      if (same) begin
        m.hit  = 1'b1;
        m.code = KEY_TABLE_CODE[i];
      end
    end
    return m;
  endfunction

endpackage

// ===== src/tked_front.sv =====
// ----------------------------------------------------------------------------
// tked_front
// byte classifier and escape sequence collector, one item per cycle while accept is high
// ----------------------------------------------------------------------------
module tked_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            accept,
  input  tked_pkg::byte_t rx_byte,
  output logic            entry_valid,
  output tked_pkg::entry_t entry
);
  import tked_pkg::*;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ESC  = 2'd1,
    MODE_SEQ  = 2'd2
  } mode_t;

  typedef struct packed {
    logic    hit;
    logic    esc;
    result_t res;
  } idle_t;

  mode_t      mode_r, mode_nxt;
  seq_len_t   len_r, len_nxt;
  seq_bytes_t seq_r, seq_nxt, seq_cand;
  match_t     match;
  idle_t      idle;
  logic       has_res;

  function automatic idle_t idle_decode(input byte_t b);
    idle_t d;
    d.hit      = 1'b1;
    d.esc      = 1'b0;
    d.res.code = KEY_CHAR;
    d.res.chr  = 8'h00;
    priority if (b == BYTE_DEL) begin
      d.res.code = KEY_BACK;
    end else if (b >= BYTE_SPACE) begin
      d.res.chr = b;
    end else if (b == BYTE_TAB) begin
      d.res.code = KEY_TAB;
    end else if (b == BYTE_CR) begin
      d.res.code = KEY_ENTER;
    end else begin
      d.hit = 1'b0;
      d.esc = (b == BYTE_ESC);
    end
    return d;
  endfunction

  // current byte dropped into its slot, if the slot is still kept
  always_comb begin
    for (int i = 0; i < SEQ_KEEP; i++) begin
      seq_cand[i] = (len_r == seq_len_t'(i)) ? rx_byte : seq_r[i];
    end
  end

  assign idle  = idle_decode(rx_byte);
  assign match = key_lookup(len_nxt, seq_cand);

  always_comb begin
    mode_nxt       = mode_r;
    len_nxt        = len_r;
    seq_nxt        = seq_r;
    has_res        = 1'b0;
    entry.two      = 1'b0;
    entry.r0.code  = KEY_CHAR;
    entry.r0.chr   = 8'h00;
    entry.r1       = idle.res;
    priority if (rx_byte == BYTE_NONE) begin
      if (mode_r == MODE_ESC) begin
        mode_nxt      = MODE_IDLE;
        has_res       = 1'b1;
        entry.r0.code = KEY_ESC;
      end
    end else if (rx_byte == BYTE_BREAK) begin
      has_res       = 1'b1;
      entry.r0.code = KEY_BREAK;
    end else begin
      unique case (mode_r)
        MODE_ESC: begin
          if ((rx_byte == BYTE_CSI) || (rx_byte == BYTE_SS3)) begin
            seq_nxt[0] = rx_byte;
            len_nxt    = seq_len_t'(1);
            mode_nxt   = MODE_SEQ;
          end else begin
            mode_nxt      = idle.esc ? MODE_ESC : MODE_IDLE;
            has_res       = 1'b1;
            entry.r0.code = KEY_ESC;
            entry.two     = idle.hit;
          end
        end
        MODE_SEQ: begin
          if (len_r < seq_len_t'(LEN_MAX)) begin
            seq_nxt = seq_cand;
            len_nxt = len_r + seq_len_t'(1);
          end
          if (rx_byte >= BYTE_FINAL_MIN) begin
            mode_nxt      = MODE_IDLE;
            has_res       = match.hit;
            entry.r0.code = match.code;
          end
        end
        default: begin
          // idle, and the unused code treated as idle
          mode_nxt = idle.esc ? MODE_ESC : MODE_IDLE;
          has_res  = idle.hit;
          entry.r0 = idle.res;
        end
      endcase
    end
  end

  assign entry_valid = accept && has_res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_IDLE;
      len_r  <= '0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      len_r  <= len_nxt;
    end
    if (accept) begin
      seq_r <= seq_nxt;
    end
  end

`ifndef SYNTHESIS
  a_seq_len: assert property (@(posedge clk) disable iff (!rst_n)
    (mode_r == MODE_SEQ) |-> ((len_r != '0) && (len_r <= seq_len_t'(LEN_MAX))))
    else $error("collecting with a bad sequence length");
`endif

endmodule

// ===== src/tked_queue.sv =====
// ----------------------------------------------------------------------------
// tked_queue
// short queue of decoded items between decoder and output side
// ----------------------------------------------------------------------------
module tked_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr,
  input  tked_pkg::entry_t  wr_entry,
  input  logic              rd,
  output tked_pkg::q_head_t head,
  output logic              full
);
  import tked_pkg::*;

  entry_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]   cnt_r;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  assign full        = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head.valid  = (cnt_r != '0);
  assign head.entry  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      unique case ({wr, rd})
        2'b10:   cnt_r <= cnt_r + QCNT_W'(1);
        2'b01:   cnt_r <= cnt_r - QCNT_W'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
    if (wr) begin
      mem_r[wr_ptr_r] <= wr_entry;
    end
  end

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count above depth");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    rd |-> head.valid)
    else $error("queue read while empty");
`endif

endmodule

// ===== src/tked_back.sv =====
// ----------------------------------------------------------------------------
// tked_back
// splits queued items into single results behind an output register
// ----------------------------------------------------------------------------
module tked_back (
  input  logic                clk,
  input  logic                rst_n,
  input  tked_pkg::q_head_t   head,
  output logic                rd,
  input  logic                out_pop,
  output logic                out_valid,
  output tked_pkg::result_t   out_res,
  output logic                out_last
);
  import tked_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_res_r, out_res_nxt;
  logic    out_last_r, out_last_nxt;
  logic    sec_valid_r, sec_valid_nxt;
  result_t sec_res_r, sec_res_nxt;
  logic    load;

  // output slot free or being taken this cycle
  assign load = !out_valid_r || out_pop;
  assign rd   = load && !sec_valid_r && head.valid;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    out_last_nxt  = out_last_r;
    sec_valid_nxt = sec_valid_r;
    sec_res_nxt   = sec_res_r;
    if (load) begin
      priority if (sec_valid_r) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = sec_res_r;
        out_last_nxt  = 1'b1;
        sec_valid_nxt = 1'b0;
      end else if (head.valid) begin
        out_valid_nxt = 1'b1;
        out_res_nxt   = head.entry.r0;
        out_last_nxt  = !head.entry.two;
        sec_valid_nxt = head.entry.two;
        sec_res_nxt   = head.entry.r1;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      sec_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      sec_valid_r <= sec_valid_nxt;
    end
    out_res_r  <= out_res_nxt;
    out_last_r <= out_last_nxt;
    sec_res_r  <= sec_res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;
  assign out_last  = out_last_r;

`ifndef SYNTHESIS
  a_sec_behind_first: assert property (@(posedge clk) disable iff (!rst_n)
    sec_valid_r |-> (out_valid_r && !out_last_r))
    else $error("second result pending without a first one shown");
`endif

endmodule

// ===== src/terminal_key_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// terminal_key_escape_decoder
// decodes received terminal bytes into key results, escape sequences included
// ----------------------------------------------------------------------------
//
//   channel  handshake           payload
//   -------  ------------------  ---------------------------------------------
//   input    push / full         in_rx_byte
//   result   empty / pop         out_key_code, out_char_value, out_last_result
//
// one item accepted per cycle while the four-entry queue has room; an item
// gives zero, one or two results, and the output side hands out one result
// per cycle while pop is high, so a stream of two-result items fills the queue
// an accepted item is written into the queue, then loaded from the queue head
// into the output register, where its first result shows on the ports
// reset (synchronous, rst_n low) returns to idle mode and empties the queue
// and the output register; the stored sequence bytes keep no reset value
// a stalled result side fills the queue and then raises full
//
module terminal_key_escape_decoder (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 push,
  output logic                 full,
  input  tked_pkg::byte_t      in_rx_byte,
  // result channel
  output logic                 empty,
  input  logic                 pop,
  output tked_pkg::key_code_t  out_key_code,
  output tked_pkg::byte_t      out_char_value,
  output logic                 out_last_result
);
  import tked_pkg::*;

  logic    in_accept;
  logic    entry_valid;
  entry_t  entry;
  q_head_t head;
  logic    q_rd;
  logic    out_valid;
  result_t out_res;

  // the queue's full flag is the input side's back-pressure
  assign in_accept = push && !full;

  // front: classifies each byte and tracks the escape state
  tked_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (in_accept),
    .rx_byte     (in_rx_byte),
    .entry_valid (entry_valid),
    .entry       (entry)
  );

  // queue: holds decoded items so either side can stall on its own
  tked_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr       (entry_valid),
    .wr_entry (entry),
    .rd       (q_rd),
    .head     (head),
    .full     (full)
  );

  // back: one result at a time, last flag on the final one of an item
  tked_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .rd        (q_rd),
    .out_pop   (pop),
    .out_valid (out_valid),
    .out_res   (out_res),
    .out_last  (out_last_result)
  );

  assign empty          = !out_valid;
  assign out_key_code   = out_res.code;
  assign out_char_value = out_res.chr;

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    entry_valid |-> !full)
    else $error("decoded item written into a full queue");
`endif

endmodule

// ===== tb/sv/tb_terminal_key_escape_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_terminal_key_escape_decoder
// self-checking bench: byte stream in, key results out, scoreboard against
// a cycle-free behavioural decoder kept alongside the device
// ----------------------------------------------------------------------------
module tb_terminal_key_escape_decoder;
  timeunit 1ns;
  timeprecision 1ps;

  import tked_pkg::*;

  // decoder mode as the bench tracks it
  typedef enum logic [1:0] {MODE_IDLE, MODE_ESC, MODE_SEQ} dec_mode_t;

  // one key result as it should leave the block
  typedef struct packed {
    key_code_t code;
    byte_t     chr;
    logic      last;
  } key_event_t;

  // one known escape sequence: length, bytes left-aligned, key it stands for
  typedef struct packed {
    logic [2:0]  len;
    logic [31:0] seq;
    key_code_t   code;
  } key_def_t;

  localparam int NUM_KEYS      = 22;
  localparam int STORED_BYTES  = 4;
  localparam int PHASE_ITEMS   = 270;
  localparam int DRAIN_CYCLES  = 20;
  localparam int LONG_HOLD     = 300;
  localparam int CYCLE_LIMIT   = 200000;

  logic        clk;
  logic        rst_n      = 1'b0;
  logic        push       = 1'b0;
  logic        pop        = 1'b0;
  byte_t       in_rx_byte = BYTE_NONE;
  logic        full;
  logic        empty;
  key_code_t   out_key_code;
  byte_t       out_char_value;
  logic        out_last_result;

  // bytes waiting to be offered, and key results still owed by the block
  byte_t       pending_bytes[$];
  key_event_t  expected_keys[$];

  // decoder state as predicted
  dec_mode_t   mode_q      = MODE_IDLE;
  int          seq_len_q   = 0;
  byte_t       seq_q [STORED_BYTES];

  // run control
  int          send_idle_pct = 9;
  int          recv_idle_pct = 84;
  int          phase_no      = 0;
  bit          long_hold_done = 1'b0;
  int          hold_left     = 0;

  // bookkeeping
  int          errors        = 0;
  int          cycle_count   = 0;
  int          bytes_taken   = 0;
  int          keys_seen     = 0;
  int          named_keys    = 0;
  int          double_items  = 0;
  int          full_cycles   = 0;

  // directed opening: every idle-mode class, esc corner cases, a few keys
  byte_t       directed_bytes[$] = '{
    BYTE_NONE, BYTE_BREAK, BYTE_DEL, BYTE_SPACE, 8'hFF, 8'h7E, BYTE_TAB, BYTE_CR,
    8'h01, 8'h1F,
    BYTE_ESC, BYTE_NONE,              // lone esc flushed by a poll tick
    BYTE_ESC, BYTE_ESC, 8'h61,        // esc esc, then esc plus a character
    BYTE_ESC, BYTE_BREAK, BYTE_NONE,  // break inside esc keeps esc pending
    BYTE_ESC, BYTE_CSI, 8'h41,        // cursor up
    BYTE_ESC, BYTE_SS3, 8'h50         // F1
  };

  terminal_key_escape_decoder u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .push            (push),
    .full            (full),
    .in_rx_byte      (in_rx_byte),
    .empty           (empty),
    .pop             (pop),
    .out_key_code    (out_key_code),
    .out_char_value  (out_char_value),
    .out_last_result (out_last_result)
  );

  // --------------------------------------------------------------------------
  // key table, written out independently of the design
  // --------------------------------------------------------------------------
  function automatic key_def_t key_def(input int idx);
    case (idx)
      0:  return '{3'd2, {BYTE_SS3, "P", 16'h0000}, KEY_F1};
      1:  return '{3'd2, {BYTE_SS3, "Q", 16'h0000}, KEY_F2};
      2:  return '{3'd2, {BYTE_SS3, "R", 16'h0000}, KEY_F3};
      3:  return '{3'd2, {BYTE_SS3, "S", 16'h0000}, KEY_F4};
      4:  return '{3'd4, {BYTE_CSI, "15~"}, KEY_F5};
      5:  return '{3'd4, {BYTE_CSI, "17~"}, KEY_F6};
      6:  return '{3'd4, {BYTE_CSI, "18~"}, KEY_F7};
      7:  return '{3'd4, {BYTE_CSI, "19~"}, KEY_F8};
      8:  return '{3'd4, {BYTE_CSI, "20~"}, KEY_F9};
      9:  return '{3'd4, {BYTE_CSI, "21~"}, KEY_F10};
      10: return '{3'd4, {BYTE_CSI, "23~"}, KEY_F11};
      11: return '{3'd4, {BYTE_CSI, "24~"}, KEY_F12};
      12: return '{3'd3, {BYTE_CSI, "2~", 8'h00}, KEY_INS};
      13: return '{3'd3, {BYTE_CSI, "3~", 8'h00}, KEY_DEL};
      14: return '{3'd3, {BYTE_CSI, "5~", 8'h00}, KEY_PGUP};
      15: return '{3'd3, {BYTE_CSI, "6~", 8'h00}, KEY_PGDN};
      16: return '{3'd2, {BYTE_CSI, "A", 16'h0000}, KEY_UP};
      17: return '{3'd2, {BYTE_CSI, "B", 16'h0000}, KEY_DOWN};
      18: return '{3'd2, {BYTE_CSI, "C", 16'h0000}, KEY_RIGHT};
      19: return '{3'd2, {BYTE_CSI, "D", 16'h0000}, KEY_LEFT};
      20: return '{3'd2, {BYTE_CSI, "F", 16'h0000}, KEY_END};
      default: return '{3'd2, {BYTE_CSI, "H", 16'h0000}, KEY_HOME};
    endcase
  endfunction

  // exact match of the collected sequence; anything over four bytes misses
  function automatic logic seq_lookup(output key_code_t code);
    key_def_t d;
    logic     same;
    code = KEY_CHAR;
    if (seq_len_q > STORED_BYTES) return 1'b0;
    for (int i = 0; i < NUM_KEYS; i++) begin
      d    = key_def(i);
      same = (int'(d.len) == seq_len_q);
      // only bytes below the collected length are ever looked at
      for (int j = 0; j < STORED_BYTES; j++) begin
        if (same && j < seq_len_q && d.seq[31-8*j -: 8] != seq_q[j]) same = 1'b0;
      end
      if (same) begin
        code = d.code;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  // idle-mode meaning of a byte other than poll and break
  function automatic logic plain_key(input byte_t b, output key_event_t ev);
    ev = '{code: KEY_CHAR, chr: 8'h00, last: 1'b0};
    if (b == BYTE_DEL) begin
      ev.code = KEY_BACK;
      return 1'b1;
    end
    if (b >= BYTE_SPACE) begin
      ev.chr = b;
      return 1'b1;
    end
    if (b == BYTE_TAB) begin
      ev.code = KEY_TAB;
      return 1'b1;
    end
    if (b == BYTE_CR) begin
      ev.code = KEY_ENTER;
      return 1'b1;
    end
    // esc opens a sequence, other control bytes are simply dropped
    if (b == BYTE_ESC) mode_q = MODE_ESC;
    return 1'b0;
  endfunction

  // advance the predicted decoder by one byte and queue what it owes
  function automatic void predict_item(input byte_t b);
    key_event_t ev [2];
    key_code_t  code;
    int         n;
    n = 0;
    ev[0] = '{code: KEY_CHAR, chr: 8'h00, last: 1'b0};
    ev[1] = ev[0];
    if (b == BYTE_NONE) begin
      // poll tick only matters when an esc is waiting
      if (mode_q == MODE_ESC) begin
        mode_q     = MODE_IDLE;
        ev[0].code = KEY_ESC;
        n          = 1;
      end
    end else if (b == BYTE_BREAK) begin
      // break in any mode, state left alone
      ev[0].code = KEY_BREAK;
      n          = 1;
    end else if (mode_q == MODE_ESC) begin
      if (b == BYTE_CSI || b == BYTE_SS3) begin
        seq_q[0]  = b;
        seq_len_q = 1;
        mode_q    = MODE_SEQ;
      end else begin
        // esc on its own, then the byte decoded afresh
        mode_q     = MODE_IDLE;
        ev[0].code = KEY_ESC;
        n          = 1;
        if (plain_key(b, ev[1])) n = 2;
      end
    end else if (mode_q == MODE_SEQ) begin
      // length saturates one below the limit, only the first bytes are kept
      if (seq_len_q < LEN_MAX) begin
        if (seq_len_q < STORED_BYTES) seq_q[seq_len_q] = b;
        seq_len_q++;
      end
      if (b >= BYTE_FINAL_MIN) begin
        mode_q = MODE_IDLE;
        if (seq_lookup(code)) begin
          ev[0].code = code;
          n          = 1;
        end
      end
    end else begin
      mode_q = MODE_IDLE;
      if (plain_key(b, ev[0])) n = 1;
    end
    for (int k = 0; k < n; k++) begin
      ev[k].last = (k == n - 1);
      expected_keys.push_back(ev[k]);
    end
    if (n == 2) double_items++;
  endfunction

  // one random burst: mostly well-formed sequences, some noise and breakage
  function automatic void add_burst();
    key_def_t d;
    int       kind;
    int       n;
    kind = $urandom_range(0, 99);
    if (kind < 40) begin
      // a known key, now and then with a break or poll slipped in
      d = key_def($urandom_range(0, NUM_KEYS - 1));
      pending_bytes.push_back(BYTE_ESC);
      for (int k = 0; k < d.len; k++) begin
        if ($urandom_range(0, 19) == 0)
          pending_bytes.push_back($urandom_range(0, 1) ? BYTE_BREAK : BYTE_NONE);
        pending_bytes.push_back(d.seq[31-8*k -: 8]);
      end
    end else if (kind < 55) begin
      pending_bytes.push_back(byte_t'($urandom_range(32, 255)));
    end else if (kind < 60) begin
      pending_bytes.push_back(byte_t'($urandom_range(0, 31)));
    end else if (kind < 66) begin
      case ($urandom_range(0, 3))
        0:       pending_bytes.push_back(BYTE_DEL);
        1:       pending_bytes.push_back(BYTE_TAB);
        2:       pending_bytes.push_back(BYTE_CR);
        default: pending_bytes.push_back(BYTE_BREAK);
      endcase
    end else if (kind < 74) begin
      // esc followed by something that is not a sequence opener, mostly
      pending_bytes.push_back(BYTE_ESC);
      case ($urandom_range(0, 3))
        0:       pending_bytes.push_back(BYTE_NONE);
        1:       pending_bytes.push_back(BYTE_ESC);
        2:       pending_bytes.push_back(byte_t'($urandom_range(1, 255)));
        default: pending_bytes.push_back(byte_t'($urandom_range(32, 126)));
      endcase
    end else if (kind < 84) begin
      // short sequence with random middle and final, rarely a real key
      pending_bytes.push_back(BYTE_ESC);
      pending_bytes.push_back($urandom_range(0, 1) ? BYTE_CSI : BYTE_SS3);
      n = $urandom_range(0, 3);
      for (int k = 0; k < n; k++) pending_bytes.push_back(byte_t'($urandom_range(1, 64)));
      pending_bytes.push_back(byte_t'($urandom_range(65, 255)));
    end else if (kind < 90) begin
      // long sequence that mostly runs the length counter into saturation
      pending_bytes.push_back(BYTE_ESC);
      pending_bytes.push_back(BYTE_CSI);
      n = $urandom_range(9, 20);
      for (int k = 0; k < n; k++) pending_bytes.push_back(byte_t'($urandom_range(32, 64)));
      pending_bytes.push_back(byte_t'($urandom_range(65, 255)));
    end else begin
      pending_bytes.push_back(byte_t'($urandom_range(0, 255)));
    end
  endfunction

  function automatic void add_random_items(input int count);
    int target;
    target = pending_bytes.size() + count;
    while (pending_bytes.size() < target) add_burst();
  endfunction

  // --------------------------------------------------------------------------
  // clock and watchdog
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d key results still owed",
               cycle_count, expected_keys.size());
      $display("terminal_key_escape_decoder: mismatch");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // driver: offers the oldest pending byte at the falling edge
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n || pending_bytes.size() == 0) begin
      push       <= 1'b0;
      in_rx_byte <= byte_t'($urandom_range(0, 255));
    end else if ($urandom_range(0, 99) < send_idle_pct) begin
      // idle cycle, junk on the data lines must be ignored
      push       <= 1'b0;
      in_rx_byte <= byte_t'($urandom_range(0, 255));
    end else begin
      push       <= 1'b1;
      in_rx_byte <= pending_bytes[0];
    end
  end

  // --------------------------------------------------------------------------
  // receiver: random pop, plus one long hold-off to back the block up
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (phase_no == 3 && !long_hold_done) begin
      hold_left      = LONG_HOLD;
      long_hold_done = 1'b1;
    end
    if (!rst_n) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // --------------------------------------------------------------------------
  // monitor: both handshakes sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    key_event_t want;
    if (rst_n) begin
      if (full) full_cycles++;
      // accepted byte: predict and retire it from the pending list
      if (push && !full) begin
        predict_item(in_rx_byte);
        void'(pending_bytes.pop_front());
        bytes_taken++;
      end
      if (pop && !empty) begin
        keys_seen++;
        if (expected_keys.size() == 0) begin
          $error("unexpected result: key_code %0d char_value 0x%02h last_result %0b",
                 out_key_code, out_char_value, out_last_result);
          errors++;
        end else begin
          want = expected_keys.pop_front();
          if (want.code >= KEY_F1) named_keys++;
          if (out_key_code !== want.code) begin
            $error("key_code: expected %0d, got %0d", want.code, out_key_code);
            errors++;
          end
          if (out_char_value !== want.chr) begin
            $error("char_value: expected 0x%02h, got 0x%02h", want.chr, out_char_value);
            errors++;
          end
          if (out_last_result !== want.last) begin
            $error("last_result: expected %0b, got %0b", want.last, out_last_result);
            errors++;
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // sequencing: reset, then three traffic phases, then drain and verdict
  // --------------------------------------------------------------------------
  initial begin : stimulus
    for (int i = 0; i < STORED_BYTES; i++) seq_q[i] = 8'h00;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // sender mostly busy, receiver mostly stalled
    phase_no      = 1;
    send_idle_pct = 9;
    recv_idle_pct = 84;
    pending_bytes = directed_bytes;
    add_random_items(PHASE_ITEMS);
    wait (pending_bytes.size() == 0);

    // sender mostly idle, receiver mostly ready
    phase_no      = 2;
    send_idle_pct = 84;
    recv_idle_pct = 9;
    add_random_items(PHASE_ITEMS);
    wait (pending_bytes.size() == 0);

    // no idling at all; the receiver's long hold-off lands here
    phase_no      = 3;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    add_random_items(PHASE_ITEMS);
    wait (pending_bytes.size() == 0);

    // let every owed result out, then watch for strays
    wait (expected_keys.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d bytes decoded into %0d key results: %0d escape keys, %0d bytes with two results",
             bytes_taken, keys_seen, named_keys, double_items);
    $display("input held off by a full queue for %0d cycles, %0d errors",
             full_cycles, errors);
    if (errors == 0) begin
      $display("terminal_key_escape_decoder: match");
    end else begin
      $display("terminal_key_escape_decoder: mismatch");
    end
    $finish;
  end

endmodule
